### design/assert_macros.svh
// assertion helpers used by the core design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked at every clock edge outside reset
`define TCMA_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequence checked in the cycle after the trigger
`define TCMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tcma_pkg.sv
package tcma_pkg;

    // history depth per channel
    localparam int MAX_WINDOW = 10;

    // fixed field widths
    localparam int HIST_W     = 12;
    localparam int WIN_W      = 4;
    localparam int OFS_W      = 11;
    localparam int TEMP_W     = 16;
    localparam int USED_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // widths that follow from the history depth
    localparam int IDX_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int CMP_W     = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int SUM_W     = HIST_W + CNT_W;
    localparam int MAG_W     = SUM_W + 4;
    localparam int DIV_STEPS = (MAG_W + 1) / 2;
    localparam int QUO_W     = 2 * DIV_STEPS;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(5);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_ON     = 2'd0,
        REG_WINDOW_SIZE   = 2'd1,
        REG_LOCAL_OFFSET  = 2'd2,
        REG_REMOTE_OFFSET = 2'd3
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              kind;
        logic signed [7:0] whole_degrees;
        logic [7:0]        extension_byte;
    } sample_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [USED_W-1:0]        samples_used;
    } result_t;

endpackage

### design/two_channel_temp_moving_average_core.sv
// flow: with filtering off an item goes from idle straight to the output register; with
// filtering on it passes through the history sum, the divider and then the output register
// throughput: one item at a time; the history memory read loop and the 2-bit-per-cycle
// divider set the pace, and the next item is taken once the result is registered
// reset: filtering off, window of 5, offsets zero, ring positions and fill counts cleared
`include "assert_macros.svh"

module two_channel_temp_moving_average_core
    import tcma_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  sample_t               sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // control state
    state_t                   state_reg, state_next;
    logic                     filter_on_reg;
    logic [WIN_W-1:0]         window_reg;
    logic signed [OFS_W-1:0]  local_ofs_reg;
    logic signed [OFS_W-1:0]  remote_ofs_reg;
    logic [IDX_W-1:0]         lslot_reg, rslot_reg;
    logic [CNT_W-1:0]         lcount_reg, rcount_reg;
    logic [CNT_W-1:0]         rd_idx_reg, rd_idx_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     result_valid_reg;

    // payload registers
    logic                     kind_reg;
    logic [CNT_W-1:0]         used_reg, used_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic                     neg_reg, neg_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic [TEMP_W-1:0]        res_reg, res_next;
    result_t                  result_reg;

    // history memory, both channels
    logic [HIST_W-1:0]        hist_mem [MEM_DEPTH];
    logic [HIST_W-1:0]        rd_data_reg;

    // sequencer outputs
    logic                     accept;
    logic                     rd_en;
    logic                     rd_more;
    logic                     sum_done;
    logic                     div_last;
    logic                     out_free;
    logic                     out_load;

    // corrected reading
    logic signed [10:0]       raw_eighths;
    logic signed [OFS_W-1:0]  cur_ofs;
    logic signed [12:0]       wide_sum;
    logic [HIST_W-1:0]        corr;

    // ring bookkeeping for the item's channel
    logic [IDX_W-1:0]         cur_slot;
    logic [CNT_W-1:0]         cur_count;
    logic [IDX_W-1:0]         slot_upd;
    logic [CNT_W-1:0]         count_upd;
    logic                     win_ok;

    // divider helpers
    logic [SUM_W-1:0]         abs_sum;
    logic [QUO_W-1:0]         quo_signed;

    assign accept   = sample_valid && !sample_stall;
    assign out_free = !result_valid_reg || !result_stall;
    assign rd_more  = rd_idx_reg < used_reg;
    assign sum_done = !rd_more && !rd_vld_reg;
    assign div_last = step_reg == STEP_W'(DIV_STEPS - 1);

    // reading in eighths plus channel offset, saturated to the history width
    always_comb
    begin
        raw_eighths = {sample.whole_degrees, sample.extension_byte[7:5]};
        cur_ofs     = sample.kind ? remote_ofs_reg : local_ofs_reg;
        wide_sum    = 13'(raw_eighths) + 13'(cur_ofs);
        if (!wide_sum[12] && wide_sum[11])
        begin
            corr = {1'b0, {(HIST_W-1){1'b1}}};
        end
        else if (wide_sum[12] && !wide_sum[11])
        begin
            corr = {1'b1, {(HIST_W-1){1'b0}}};
        end
        else
        begin
            corr = wide_sum[HIST_W-1:0];
        end
    end

    // next ring slot and fill count of the item's channel
    always_comb
    begin
        cur_slot  = sample.kind ? rslot_reg : lslot_reg;
        cur_count = sample.kind ? rcount_reg : lcount_reg;
        if (CMP_W'(cur_slot) + CMP_W'(1) == CMP_W'(window_reg))
        begin
            slot_upd = '0;
        end
        else
        begin
            slot_upd = cur_slot + IDX_W'(1);
        end
        if (CMP_W'(cur_count) < CMP_W'(window_reg))
        begin
            count_upd = cur_count + CNT_W'(1);
        end
        else
        begin
            count_upd = cur_count;
        end
    end

    assign win_ok = (cfg_data[WIN_W-1:0] != '0)
        && (CMP_W'(cfg_data[WIN_W-1:0]) <= CMP_W'(MAX_WINDOW));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = filter_on_reg ? S_SUM : S_DONE;
                end
            end
            S_SUM:
            begin
                if (sum_done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        sample_stall = 1'b1;
        rd_en        = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                sample_stall = 1'b0;
            end
            S_SUM:
            begin
                rd_en = rd_more;
            end
            S_DIV:
            begin
                rd_en = 1'b0;
            end
            S_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                sample_stall = 1'b1;
            end
        endcase
    end

    // sum, divide and result datapath
    always_comb
    begin
        logic [CNT_W:0]   trial;
        logic [CNT_W-1:0] r;
        logic [QUO_W-1:0] q;

        rd_idx_next = rd_idx_reg;
        rd_vld_next = 1'b0;
        step_next   = step_reg;
        used_next   = used_reg;
        sum_next    = sum_reg;
        neg_next    = neg_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        res_next    = res_reg;
        abs_sum     = sum_reg[SUM_W-1] ? SUM_W'(~sum_reg + SUM_W'(1)) : SUM_W'(sum_reg);
        r           = rem_reg;
        q           = quo_reg;

        // two restoring steps of the divider
        for (int k = 0; k < 2; k++)
        begin
            trial = {r, q[QUO_W-1]};
            q     = {q[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, used_reg})
            begin
                trial = trial - {1'b0, used_reg};
                q[0]  = 1'b1;
            end
            r = trial[CNT_W-1:0];
        end
        quo_signed = neg_reg ? (~q + QUO_W'(1)) : q;

        case (state_reg)
            S_IDLE:
            begin
                rd_idx_next = '0;
                sum_next    = '0;
                if (accept)
                begin
                    if (filter_on_reg)
                    begin
                        used_next = count_upd;
                    end
                    else
                    begin
                        used_next = CNT_W'(1);
                        res_next  = {corr, 4'b0000};
                    end
                end
            end
            S_SUM:
            begin
                // accumulate the entry read in the previous cycle
                if (rd_vld_reg)
                begin
                    sum_next = sum_reg + SUM_W'($signed(rd_data_reg));
                end
                if (rd_more)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    rd_vld_next = 1'b1;
                end
                if (sum_done)
                begin
                    neg_next  = sum_reg[SUM_W-1];
                    quo_next  = QUO_W'({abs_sum, 4'b0000});
                    rem_next  = '0;
                    step_next = '0;
                end
            end
            S_DIV:
            begin
                quo_next  = q;
                rem_next  = r;
                step_next = step_reg + STEP_W'(1);
                if (div_last)
                begin
                    res_next = quo_signed[TEMP_W-1:0];
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            filter_on_reg    <= 1'b0;
            window_reg       <= WINDOW_RESET;
            local_ofs_reg    <= '0;
            remote_ofs_reg   <= '0;
            lslot_reg        <= '0;
            rslot_reg        <= '0;
            lcount_reg       <= '0;
            rcount_reg       <= '0;
            rd_idx_reg       <= '0;
            rd_vld_reg       <= 1'b0;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            rd_vld_reg <= rd_vld_next;
            step_reg   <= step_next;

            // ring update of the item's channel
            if (accept && filter_on_reg)
            begin
                if (sample.kind)
                begin
                    rslot_reg  <= slot_upd;
                    rcount_reg <= count_upd;
                end
                else
                begin
                    lslot_reg  <= slot_upd;
                    lcount_reg <= count_upd;
                end
            end

            // configuration writes; mode and window writes clear the history
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_FILTER_ON:
                    begin
                        filter_on_reg <= cfg_data[0];
                        lslot_reg     <= '0;
                        rslot_reg     <= '0;
                        lcount_reg    <= '0;
                        rcount_reg    <= '0;
                    end
                    REG_WINDOW_SIZE:
                    begin
                        if (win_ok)
                        begin
                            window_reg <= cfg_data[WIN_W-1:0];
                        end
                        lslot_reg  <= '0;
                        rslot_reg  <= '0;
                        lcount_reg <= '0;
                        rcount_reg <= '0;
                    end
                    REG_LOCAL_OFFSET:
                    begin
                        local_ofs_reg <= $signed(cfg_data[OFS_W-1:0]);
                    end
                    REG_REMOTE_OFFSET:
                    begin
                        remote_ofs_reg <= $signed(cfg_data[OFS_W-1:0]);
                    end
                    default:
                    begin
                        filter_on_reg <= filter_on_reg;
                    end
                endcase
            end

            // output register
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        used_reg <= used_next;
        sum_reg  <= sum_next;
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        if (accept)
        begin
            kind_reg <= sample.kind;
        end
        if (out_load)
        begin
            result_reg.temperature  <= $signed(res_reg);
            result_reg.samples_used <= USED_W'(used_reg);
        end
    end

    // history memory: write at accept with filtering on, registered read during the sum
    always_ff @(posedge clk)
    begin
        if (accept && filter_on_reg)
        begin
            hist_mem[{sample.kind, cur_slot}] <= corr;
        end
        if (rd_en)
        begin
            rd_data_reg <= hist_mem[{kind_reg, rd_idx_reg[IDX_W-1:0]}];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    `TCMA_ASSERT(a_lcount_in_window, CMP_W'(lcount_reg) <= CMP_W'(window_reg), "local fill count above window")
    `TCMA_ASSERT(a_rslot_in_window, CMP_W'(rslot_reg) < CMP_W'(window_reg), "remote ring slot outside window")
    `TCMA_ASSERT(a_sum_idx_bound, (state_reg != S_SUM) || (rd_idx_reg <= used_reg), "sum read index past fill count")
    `TCMA_ASSERT_NEXT(a_bypass_direct, accept && !filter_on_reg, state_reg == S_DONE, "unfiltered item did not go to result")

endmodule

### test/two_channel_temp_moving_average_core_tb.sv
`timescale 1ns / 1ps

module two_channel_temp_moving_average_core_tb;
    import tcma_pkg::*;

    // directed plan row types
    typedef enum logic {
        ROW_READING,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t              op;
        cfg_reg_t               reg_idx;
        logic [CFG_DATA_W-1:0]  wdata;
        sample_t                reading;
        bit                     typed;
        result_t                want;
    } plan_row_t;

    localparam int CORR_MAX      = (1 << (HIST_W - 1)) - 1;
    localparam int CORR_MIN      = -(1 << (HIST_W - 1));
    localparam int RANDOM_ITEMS  = 1150;
    localparam int PAUSE_AT_ITEM = 400;
    localparam int TAIL_CYCLES   = 30;
    localparam int PRINT_LIMIT   = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_stall;
    sample_t               sample;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow configuration and per-channel rings
    logic                     filter_en;
    logic [WIN_W-1:0]         win_len;
    logic signed [OFS_W-1:0]  local_ofs;
    logic signed [OFS_W-1:0]  remote_ofs;
    logic signed [HIST_W-1:0] ring [2][MAX_WINDOW];
    int                       ring_slot [2];
    int                       ring_fill [2];

    result_t   pending_results[$];
    plan_row_t stim_plan[$];
    int        mismatch_count = 0;
    int        random_sent = 0;
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;

    two_channel_temp_moving_average_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #800000;
        $display("two_channel_temp_moving_average_core test failed");
        $finish;
    end

    // history clear on filter or window writes
    function automatic void clear_rings();
        for (int c = 0; c < 2; c++)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
                ring[c][i] = '0;
            ring_slot[c] = 0;
            ring_fill[c] = 0;
        end
    endfunction

    // shadow register update
    function automatic void apply_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
        int w;
        case (idx)
            REG_FILTER_ON:
            begin
                filter_en = d[0];
                clear_rings();
            end
            REG_WINDOW_SIZE:
            begin
                w = int'(d[WIN_W-1:0]);
                if (w >= 1 && w <= MAX_WINDOW)
                    win_len = w[WIN_W-1:0];
                clear_rings();
            end
            REG_LOCAL_OFFSET:  local_ofs = d[OFS_W-1:0];
            REG_REMOTE_OFFSET: remote_ofs = d[OFS_W-1:0];
            default: ;
        endcase
    endfunction

    // corrected reading, ring update and mean for one item
    function automatic result_t predict_reading(input sample_t s);
        result_t r;
        int      corr;
        int      acc;
        int      used;
        int      ch;
        int      w;
        ch = int'(s.kind);
        corr = int'($signed(s.whole_degrees)) * 8 + int'(s.extension_byte[7:5])
             + (s.kind ? int'(remote_ofs) : int'(local_ofs));
        if (corr > CORR_MAX)
            corr = CORR_MAX;
        if (corr < CORR_MIN)
            corr = CORR_MIN;
        if (filter_en)
        begin
            w = int'(win_len);
            if (ring_slot[ch] >= w)
                ring_slot[ch] = 0;
            ring[ch][ring_slot[ch]] = corr[HIST_W-1:0];
            ring_slot[ch] = (ring_slot[ch] + 1) % w;
            if (ring_fill[ch] < w)
                ring_fill[ch]++;
            used = ring_fill[ch];
            acc = 0;
            for (int i = 0; i < used; i++)
                acc += ring[ch][i];
            acc = (acc * 16) / used;
        end
        else
        begin
            acc = corr * 16;
            used = 1;
        end
        r.temperature = acc[TEMP_W-1:0];
        r.samples_used = used[USED_W-1:0];
        return r;
    endfunction

    function automatic void plan_read(input logic k, input logic [7:0] whole,
                                      input logic [7:0] ext, input bit typed,
                                      input int temp, input int used);
        plan_row_t row;
        row.op = ROW_READING;
        row.reg_idx = REG_FILTER_ON;
        row.wdata = '0;
        row.reading = '{kind: k, whole_degrees: whole, extension_byte: ext};
        row.typed = typed;
        row.want.temperature = temp[TEMP_W-1:0];
        row.want.samples_used = used[USED_W-1:0];
        stim_plan.push_back(row);
    endfunction

    function automatic void plan_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
        plan_row_t row;
        row.op = ROW_WRITE;
        row.reg_idx = idx;
        row.wdata = d;
        row.reading = '0;
        row.typed = 1'b0;
        row.want = '0;
        stim_plan.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // hold the sender until every outstanding result is back
    task automatic drain_results();
        if (sample_valid)
            sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // one register write; caller lowers the enable after the last one
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        apply_reg(idx, d);
    endtask

    // present one item and hold it until taken
    task automatic send_item(input sample_t s, input bit typed, input result_t typed_want);
        result_t want;
        sample_valid <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (sample_stall);
        want = predict_reading(s);
        if (typed)
            want = typed_want;
        pending_results.push_back(want);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_offset();
        case ($urandom_range(0, 5))
            0: return 11'h3FF;
            1: return 11'h400;
            2: return '0;
            default: return CFG_DATA_W'($urandom_range(0, 2047));
        endcase
    endfunction

    function automatic sample_t random_reading();
        sample_t s;
        logic [7:0] extremes [4] = '{8'h80, 8'h7F, 8'h00, 8'hFF};
        s.kind = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 15)
            s.whole_degrees = extremes[$urandom_range(0, 3)];
        else
            s.whole_degrees = 8'($urandom_range(0, 255));
        s.extension_byte = 8'($urandom_range(0, 255));
        return s;
    endfunction

    // register settings for one random phase; the first few hit the extremes
    task automatic configure_phase(input int p);
        logic [CFG_DATA_W-1:0] d;
        int w;
        bit wrote;
        wrote = 1'b0;
        drain_results();
        case (p)
            0:
            begin
                write_reg(REG_LOCAL_OFFSET, 11'h3FF);
                write_reg(REG_REMOTE_OFFSET, 11'h400);
                write_reg(REG_FILTER_ON, 11'h001);
                write_reg(REG_WINDOW_SIZE, 11'h00A);
                wrote = 1'b1;
            end
            1:
            begin
                write_reg(REG_LOCAL_OFFSET, 11'h400);
                write_reg(REG_REMOTE_OFFSET, 11'h3FF);
                write_reg(REG_WINDOW_SIZE, 11'h001);
                wrote = 1'b1;
            end
            2:
            begin
                // bit 0 clear turns filtering off whatever the upper bits hold
                write_reg(REG_FILTER_ON, 11'h7FE);
                write_reg(REG_LOCAL_OFFSET, 11'h000);
                write_reg(REG_REMOTE_OFFSET, 11'h000);
                wrote = 1'b1;
            end
            3:
            begin
                write_reg(REG_FILTER_ON, 11'h7FF);
                write_reg(REG_WINDOW_SIZE, 11'h7FA);
                // out-of-range window keeps ten but still clears
                write_reg(REG_WINDOW_SIZE, 11'h00F);
                wrote = 1'b1;
            end
            default:
            begin
                if ($urandom_range(0, 1))
                begin
                    write_reg(REG_LOCAL_OFFSET, random_offset());
                    wrote = 1'b1;
                end
                if ($urandom_range(0, 1))
                begin
                    write_reg(REG_REMOTE_OFFSET, random_offset());
                    wrote = 1'b1;
                end
                if ($urandom_range(0, 2) != 0)
                begin
                    d = CFG_DATA_W'($urandom_range(0, 2047));
                    d[0] = ($urandom_range(0, 3) != 0);
                    write_reg(REG_FILTER_ON, d);
                    wrote = 1'b1;
                end
                if ($urandom_range(0, 2) != 0)
                begin
                    w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                    : $urandom_range(1, MAX_WINDOW);
                    d = CFG_DATA_W'($urandom_range(0, 2047));
                    d[WIN_W-1:0] = w[WIN_W-1:0];
                    write_reg(REG_WINDOW_SIZE, d);
                    wrote = 1'b1;
                end
            end
        endcase
        if (wrote)
            cfg_we <= 1'b0;
    endtask

    // receiver stall pattern, switching style every so often
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(20, 200);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 99) < 30);
            2: result_stall <= ($urandom_range(0, 99) < 85);
            default: result_stall <= ~result_stall;
        endcase
    end

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected item, temperature",
                                int'($signed(result.temperature)), 0);
            else
            begin
                want = pending_results.pop_front();
                if (result.temperature !== want.temperature)
                    report_mismatch("temperature", int'($signed(result.temperature)),
                                    int'($signed(want.temperature)));
                if (result.samples_used !== want.samples_used)
                    report_mismatch("samples_used", int'(result.samples_used),
                                    int'(want.samples_used));
            end
        end
    end

    // stimulus
    initial
    begin
        plan_row_t row;
        int        phase;
        int        phase_items;
        int        burst_left;
        int        gap;
        bit        gapless;

        rst_n <= 1'b0;
        sample_valid <= 1'b0;
        sample <= '0;
        result_stall <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_FILTER_ON;
        cfg_data <= '0;

        filter_en = 1'b0;
        win_len = WINDOW_RESET;
        local_ofs = '0;
        remote_ofs = '0;
        clear_rings();

        // reset state: pass-through, no offsets
        plan_read(1'b0, 8'h00, 8'h00, 1, 0, 1);
        plan_read(1'b0, 8'h7F, 8'hE0, 1, 16368, 1);
        plan_read(1'b1, 8'h80, 8'h00, 1, -16384, 1);
        plan_read(1'b1, 8'hFF, 8'hFF, 1, -16, 1);
        plan_read(1'b0, 8'h55, 8'h1F, 1, 10880, 1);
        // offset extremes reach the bottom of the corrected range and one below its top
        plan_write(REG_LOCAL_OFFSET, 11'h3FF);
        plan_write(REG_REMOTE_OFFSET, 11'h400);
        plan_read(1'b0, 8'h7F, 8'hE0, 1, 32736, 1);
        plan_read(1'b1, 8'h80, 8'h00, 1, -32768, 1);
        plan_read(1'b1, 8'h7F, 8'hE0, 1, -16, 1);
        plan_read(1'b0, 8'h80, 8'h00, 1, -16, 1);
        // filtering on, window of five, local ring wraps
        plan_write(REG_FILTER_ON, 11'h001);
        plan_read(1'b0, 8'h10, 8'h20, 0, 0, 0);
        plan_read(1'b1, 8'hF0, 8'hA0, 0, 0, 0);
        plan_read(1'b0, 8'h7F, 8'hE0, 0, 0, 0);
        plan_read(1'b0, 8'h80, 8'h00, 0, 0, 0);
        plan_read(1'b0, 8'h05, 8'h60, 0, 0, 0);
        plan_read(1'b0, 8'hC3, 8'hFF, 0, 0, 0);
        plan_read(1'b0, 8'h22, 8'h40, 0, 0, 0);
        // window of one
        plan_write(REG_WINDOW_SIZE, 11'h001);
        plan_read(1'b0, 8'h33, 8'h80, 0, 0, 0);
        plan_read(1'b1, 8'hDE, 8'hC0, 0, 0, 0);
        // zero window write keeps three but clears the rings
        plan_write(REG_WINDOW_SIZE, 11'h003);
        plan_read(1'b1, 8'h12, 8'h20, 0, 0, 0);
        plan_write(REG_WINDOW_SIZE, 11'h000);
        plan_read(1'b0, 8'h01, 8'h20, 0, 0, 0);
        plan_read(1'b0, 8'h02, 8'h40, 0, 0, 0);
        plan_read(1'b0, 8'h03, 8'h60, 0, 0, 0);
        plan_read(1'b0, 8'h04, 8'h80, 0, 0, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk
        foreach (stim_plan[i])
        begin
            row = stim_plan[i];
            if (row.op == ROW_WRITE)
            begin
                drain_results();
                write_reg(row.reg_idx, row.wdata);
                if (i + 1 >= stim_plan.size() || stim_plan[i + 1].op != ROW_WRITE)
                    cfg_we <= 1'b0;
            end
            else
                send_item(row.reading, row.typed, row.want);
        end

        // random phases
        phase = 0;
        burst_left = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            configure_phase(phase);
            phase++;
            gapless = ($urandom_range(0, 3) == 0);
            phase_items = $urandom_range(40, 140);
            for (int n = 0; n < phase_items && random_sent < RANDOM_ITEMS; n++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap = gapless ? 0 : $urandom_range(0, 7);
                    if (gap != 0)
                    begin
                        sample_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
                burst_left--;
                // one pause mid-phase until everything in flight has come back
                if (random_sent == PAUSE_AT_ITEM)
                    drain_results();
                send_item(random_reading(), 1'b0, '0);
                random_sent++;
            end
        end

        // wind down
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("two_channel_temp_moving_average_core test passed");
        else
            $display("two_channel_temp_moving_average_core test failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/tcma_pkg.sv
design/two_channel_temp_moving_average_core.sv
test/two_channel_temp_moving_average_core_tb.sv
